// File: design/rah_pkg.sv
// Package for the region access heatmap: shared constants, status codes and types.
// No dependencies.
package rah_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned RegionShift  = 21;
  localparam int unsigned PidW   = 23;
  localparam int unsigned NodeW  = 7;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned LenW   = 16;
  localparam int unsigned KeyOutW = 43;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned RNodeW = 8;
  localparam int unsigned StatW  = 2;

  // Byte address of the watched_process register.
  localparam logic [1:0] AddrWatched = 2'd0;

  typedef enum logic [1:0] {
    StatRecorded = 2'd0,
    StatIgnored  = 2'd1,
    StatFull     = 2'd2
  } status_e;

  localparam logic [TypeW-1:0]  TypeMixed = '1;
  localparam logic [RNodeW-1:0] NodeMixed = '1;

endpackage

// File: design/rah_if.sv
// Valid/ready channel interfaces for the region access heatmap.
// Depends on rah_pkg for field widths.
interface rah_in_if;
  logic                       valid;
  logic                       ready;
  logic [rah_pkg::PidW-1:0]   process_id;
  logic [rah_pkg::NodeW-1:0]  memory_node;
  logic [rah_pkg::AddrW-1:0]  address;
  logic [rah_pkg::LenW-1:0]   access_length;
  logic                       is_anonymous;
  modport source (output valid, process_id, memory_node, address, access_length,
                  is_anonymous, input ready);
  modport sink (input valid, process_id, memory_node, address, access_length,
                is_anonymous, output ready);
endinterface

interface rah_out_if;
  logic                        valid;
  logic                        ready;
  logic [rah_pkg::StatW-1:0]   status;
  logic [rah_pkg::KeyOutW-1:0] region_key;
  logic                        was_new_region;
  logic [rah_pkg::LenW-1:0]    region_accesses;
  logic signed [rah_pkg::TypeW-1:0]  region_mem_type;
  logic signed [rah_pkg::RNodeW-1:0] region_node;
  modport source (output valid, status, region_key, was_new_region, region_accesses,
                  region_mem_type, region_node, input ready);
  modport sink (input valid, status, region_key, was_new_region, region_accesses,
                region_mem_type, region_node, output ready);
endinterface

// File: design/rah_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rah_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: design/region_access_heatmap.sv
// Region access heatmap top level: APB register, sequencer, key scan over the slot RAM.
// Depends on rah_pkg, rah_if and rah_ram.
// A watched process's event reads and compares the used slots in order until a hit; a new region
// or a full table scans every used slot; another process's event goes straight to the result. One
// event at a time; the next is taken in the cycle after the result leaves, a stalled result holds
// the input. Reset empties the table through the used-slot count; watched_process resets to 0.
module region_access_heatmap #(
  parameter int unsigned TableEntries = rah_pkg::TableEntries,
  parameter int unsigned RegionShift  = rah_pkg::RegionShift
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rah_in_if.sink      in_if,
  rah_out_if.source   out_if
);
  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned FKeyW = rah_pkg::AddrW - RegionShift;
  localparam int unsigned EntW  = FKeyW + rah_pkg::LenW + rah_pkg::TypeW + rah_pkg::RNodeW;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StCmp   = 5'b00100,
    StWrite = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [rah_pkg::PidW-1:0] watch_q;
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [FKeyW-1:0] key_q;
  logic [rah_pkg::NodeW-1:0] node_q;
  logic [rah_pkg::LenW-1:0] len_q;
  logic anon_q;

  logic we;
  logic [IdxW-1:0] ram_addr;
  logic [EntW-1:0] wdata, rdata;
  logic [FKeyW-1:0] r_key;
  logic [rah_pkg::LenW-1:0] r_cnt, n_cnt;
  logic [rah_pkg::TypeW-1:0] r_type, n_type;
  logic [rah_pkg::RNodeW-1:0] r_node, n_node;
  logic hit;

  logic [rah_pkg::StatW-1:0] stat_q;
  logic new_q;
  logic [rah_pkg::LenW-1:0] ocnt_q;
  logic [rah_pkg::TypeW-1:0] otype_q;
  logic [rah_pkg::RNodeW-1:0] onode_q;

  assign pready = 1'b1;
  assign prdata = (paddr == rah_pkg::AddrWatched) ? {{(32 - rah_pkg::PidW){1'b0}}, watch_q}
                                                  : 32'd0;

  assign {r_key, r_cnt, r_type, r_node} = rdata;
  assign hit = (r_key == key_q);
  assign n_cnt = hit ? r_cnt + len_q : len_q;
  assign n_type = (hit && r_type != {1'b0, anon_q}) ? rah_pkg::TypeMixed
                : hit ? r_type : {1'b0, anon_q};
  assign n_node = (hit && r_node != {1'b0, node_q}) ? rah_pkg::NodeMixed
                : hit ? r_node : {1'b0, node_q};
  // The result registers already hold the updated entry by the time the slot is written.
  assign wdata = {key_q, ocnt_q, otype_q, onode_q};
  assign ram_addr = idx_q[IdxW-1:0];
  assign we = (state_q == StWrite) && (stat_q != rah_pkg::StatFull);

  rah_ram #(.Width(EntW), .Depth(TableEntries)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ram_addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.status = stat_q;
  assign out_if.region_key = rah_pkg::KeyOutW'(key_q);
  assign out_if.was_new_region = new_q;
  assign out_if.region_accesses = ocnt_q;
  assign out_if.region_mem_type = otype_q;
  assign out_if.region_node = onode_q;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        if (in_if.valid) begin
          state_d = (in_if.process_id == watch_q) ? StRead : StOut;
        end
      end
      StRead: begin
        // Reaching the end of the used slots means a straight insert or a full report.
        if (idx_q >= used_q) state_d = StWrite;
        else state_d = StCmp;
      end
      StCmp: begin
        if (hit) state_d = StWrite;
        else begin
          idx_d = idx_q + 1'b1;
          state_d = StRead;
        end
      end
      StWrite: state_d = StOut;
      StOut: if (out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      watch_q <= '0;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (psel && penable && pwrite && paddr == rah_pkg::AddrWatched) begin
        watch_q <= pwdata[rah_pkg::PidW-1:0];
      end
      if (state_q == StWrite && idx_q == used_q && used_q < CntW'(TableEntries)) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  // The transaction's fields and the result are captured here. A full table leaves the
  // status at full, which also keeps the slot RAM from being written.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_if.valid) begin
      key_q  <= (in_if.process_id == watch_q) ? in_if.address[rah_pkg::AddrW-1:RegionShift]
                                              : '0;
      node_q <= in_if.memory_node;
      len_q  <= in_if.access_length;
      anon_q <= in_if.is_anonymous;
      stat_q <= (in_if.process_id == watch_q) ? rah_pkg::StatRecorded
                                              : rah_pkg::StatIgnored;
      new_q  <= 1'b0;
      ocnt_q <= '0;
      otype_q <= '0;
      onode_q <= '0;
    end
    if (state_q == StCmp && hit) begin
      ocnt_q <= n_cnt; otype_q <= n_type; onode_q <= n_node;
    end
    if (state_q == StRead && idx_q >= used_q) begin
      if (used_q >= CntW'(TableEntries)) begin
        stat_q <= rah_pkg::StatFull;
      end else begin
        new_q <= 1'b1;
        ocnt_q <= len_q;
        otype_q <= {1'b0, anon_q};
        onode_q <= {1'b0, node_q};
      end
    end
  end
endmodule
